### rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define OPR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define OPR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/opr_pkg.sv
// Shared types and constants of the optimal page replacement simulator.
package opr_pkg;

    // Default sizes of the reference store and the frame set.
    localparam int DEF_MAX_REFS   = 256;
    localparam int DEF_MAX_FRAMES = 16;

    // Field widths of the channels and the register.
    localparam int PAGE_W   = 8;
    localparam int COUNT_W  = 9;
    localparam int FC_W     = 5;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 24;

    localparam logic [FC_W-1:0] FC_RESET = 5'd4;

    // Controller states.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FETCH,
        ST_CHECK,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_FINISH
    } opr_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic rd_cur;
        logic check;
        logic rd_scan;
        logic scan_cmp;
        logic replace_unfound;
        logic next_ref;
        logic finish;
    } opr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic has_empty;
        logic cur_last;
        logic scan_end;
        logic all_found;
        logic out_free;
    } opr_status_t;

endpackage

### rtl/opr_ctrl.sv
// Controller state machine that sequences loading and the replacement simulation.
module opr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic                in_last,
    input  opr_pkg::opr_status_t st,
    output logic                in_ready,
    output opr_pkg::opr_cmd_t   cmd
);
    import opr_pkg::*;

    opr_state_t state_reg;
    opr_state_t state_next;
    logic       ref_done_next_state;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // After a reference is resolved, go to the next one or deliver the result.
    assign ref_done_next_state = st.cur_last;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (in_valid && in_last) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (st.hit || st.has_empty) begin
                    state_next = ref_done_next_state ? ST_FINISH : ST_FETCH;
                end else begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                if (st.scan_end) begin
                    state_next = ref_done_next_state ? ST_FINISH : ST_FETCH;
                end else begin
                    state_next = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP: begin
                if (st.all_found) begin
                    state_next = ref_done_next_state ? ST_FINISH : ST_FETCH;
                end else begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_FINISH: begin
                if (st.out_free) begin
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_FETCH: begin
                cmd.rd_cur = 1'b1;
            end
            ST_CHECK: begin
                cmd.check    = 1'b1;
                cmd.next_ref = st.hit || st.has_empty;
            end
            ST_SCAN_RD: begin
                cmd.rd_scan         = !st.scan_end;
                cmd.replace_unfound = st.scan_end;
                cmd.next_ref        = st.scan_end;
            end
            ST_SCAN_CMP: begin
                cmd.scan_cmp = 1'b1;
                cmd.next_ref = st.all_found;
            end
            ST_FINISH: begin
                cmd.finish = st.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

### rtl/opr_dp.sv
// Datapath: reference store, page frames, counters and the result register.
module opr_dp #(
    parameter int MAX_REFS   = opr_pkg::DEF_MAX_REFS,
    parameter int MAX_FRAMES = opr_pkg::DEF_MAX_FRAMES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  opr_pkg::opr_cmd_t             cmd,
    input  logic [opr_pkg::PAGE_W-1:0]    in_page,
    input  logic                          cfg_wr_en,
    input  logic [opr_pkg::FC_W-1:0]      cfg_wr_data,
    input  logic                          out_ready,
    output opr_pkg::opr_status_t          st,
    output logic                          out_valid,
    output logic [opr_pkg::M_DATA_W-1:0]  out_data
);
    import opr_pkg::*;

    localparam int ADDR_W = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
    localparam int LEN_W  = $clog2(MAX_REFS + 1);
    localparam int FIDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int NF_W   = $clog2(MAX_FRAMES + 1);
    localparam int CMP_W  = (NF_W > FC_W) ? NF_W : FC_W;
    localparam int PAD_W  = M_DATA_W - 2 * COUNT_W - 1;

    // Reference store.
    logic [PAGE_W-1:0] ref_mem [MAX_REFS];
    logic [PAGE_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;

    // Run state.
    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   i_reg;
    logic [LEN_W-1:0]   k_reg;
    logic [COUNT_W-1:0] hits_reg;
    logic [COUNT_W-1:0] misses_reg;
    logic               dropped_reg;
    logic [FC_W-1:0]    fc_reg;
    logic [PAGE_W-1:0]  cur_page_reg;

    // Frames.
    logic [PAGE_W-1:0]     frame_pages_reg [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] frame_valid_reg;
    logic [MAX_FRAMES-1:0] found_reg;

    // Result register.
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    // Derived values.
    logic [CMP_W-1:0]      fc_ext;
    logic [CMP_W-1:0]      nf;
    logic [MAX_FRAMES-1:0] use_mask;
    logic [MAX_FRAMES-1:0] hit_vec;
    logic [MAX_FRAMES-1:0] empty_vec;
    logic [MAX_FRAMES-1:0] match_vec;
    logic [MAX_FRAMES-1:0] unfound_vec;
    logic [FIDX_W-1:0]     empty_idx;
    logic [FIDX_W-1:0]     match_idx;
    logic [FIDX_W-1:0]     unfound_idx;
    logic                  store_full;
    logic [LEN_W-1:0]      i_plus1;

    // Frame write port.
    logic              fr_we;
    logic              fr_set_valid;
    logic [FIDX_W-1:0] fr_widx;
    logic [PAGE_W-1:0] fr_wdata;

    // Frames in use: a zero count means one frame, large counts are clamped.
    assign fc_ext = CMP_W'(fc_reg);
    always_comb begin
        if (fc_ext == '0) begin
            nf = CMP_W'(1);
        end else if (fc_ext > CMP_W'(MAX_FRAMES)) begin
            nf = CMP_W'(MAX_FRAMES);
        end else begin
            nf = fc_ext;
        end
    end

    // Per-frame compares against the page just read from the store.
    always_comb begin
        for (int j = 0; j < MAX_FRAMES; j++) begin
            use_mask[j]    = CMP_W'(j) < nf;
            hit_vec[j]     = use_mask[j] && frame_valid_reg[j]
                             && (frame_pages_reg[j] == rd_data_reg);
            empty_vec[j]   = use_mask[j] && !frame_valid_reg[j];
            match_vec[j]   = use_mask[j] && (frame_pages_reg[j] == rd_data_reg);
            unfound_vec[j] = use_mask[j] && !found_reg[j];
        end
    end

    // Lowest empty frame, the matching frame, and the highest unfound frame.
    always_comb begin
        empty_idx   = '0;
        match_idx   = '0;
        unfound_idx = '0;
        for (int j = MAX_FRAMES - 1; j >= 0; j--) begin
            if (empty_vec[j]) begin
                empty_idx = FIDX_W'(j);
            end
        end
        for (int j = 0; j < MAX_FRAMES; j++) begin
            if (match_vec[j]) begin
                match_idx = FIDX_W'(j);
            end
            if (unfound_vec[j]) begin
                unfound_idx = FIDX_W'(j);
            end
        end
    end

    assign store_full = (len_reg == LEN_W'(MAX_REFS));
    assign i_plus1    = LEN_W'(i_reg + LEN_W'(1));

    // Status back to the controller.
    always_comb begin
        st.hit       = |hit_vec;
        st.has_empty = |empty_vec;
        st.cur_last  = (i_plus1 == len_reg);
        st.scan_end  = (k_reg == len_reg);
        st.all_found = (((found_reg | match_vec) & use_mask) == use_mask);
        st.out_free  = !out_valid_reg || out_ready;
    end

    // Store read address: the current reference or the one under scan.
    assign rd_addr = cmd.rd_cur ? i_reg[ADDR_W-1:0] : k_reg[ADDR_W-1:0];

    // Reference store, one write and one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.accept && !store_full) begin
            ref_mem[len_reg[ADDR_W-1:0]] <= in_page;
        end
        if (cmd.rd_cur || cmd.rd_scan) begin
            rd_data_reg <= ref_mem[rd_addr];
        end
    end

    // Frame write selection: fill an empty frame or replace the victim.
    always_comb begin
        fr_we        = 1'b0;
        fr_set_valid = 1'b0;
        fr_widx      = empty_idx;
        fr_wdata     = cur_page_reg;
        if (cmd.check && !st.hit && st.has_empty) begin
            fr_we        = 1'b1;
            fr_set_valid = 1'b1;
            fr_wdata     = rd_data_reg;
        end else if (cmd.scan_cmp && st.all_found) begin
            fr_we   = 1'b1;
            fr_widx = match_idx;
        end else if (cmd.replace_unfound) begin
            fr_we   = 1'b1;
            fr_widx = unfound_idx;
        end
    end

    // Frame pages carry no reset; they are read only while valid.
    always_ff @(posedge aclk) begin
        if (fr_we) begin
            frame_pages_reg[fr_widx] <= fr_wdata;
        end
    end

    // Current page of a miss, kept for the replacement after the scan.
    always_ff @(posedge aclk) begin
        if (cmd.check) begin
            cur_page_reg <= rd_data_reg;
        end
    end

    // Frame count register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fc_reg <= FC_RESET;
        end else if (cfg_wr_en) begin
            fc_reg <= cfg_wr_data;
        end
    end

    // Run control: length, positions, counters, valid and found bits.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.finish) begin
            len_reg         <= '0;
            i_reg           <= '0;
            k_reg           <= '0;
            hits_reg        <= '0;
            misses_reg      <= '0;
            dropped_reg     <= 1'b0;
            frame_valid_reg <= '0;
            found_reg       <= '0;
        end else begin
            if (cmd.accept) begin
                if (store_full) begin
                    dropped_reg <= 1'b1;
                end else begin
                    len_reg <= LEN_W'(len_reg + LEN_W'(1));
                end
            end
            if (cmd.check) begin
                if (st.hit) begin
                    hits_reg <= COUNT_W'(hits_reg + COUNT_W'(1));
                end else begin
                    misses_reg <= COUNT_W'(misses_reg + COUNT_W'(1));
                end
                k_reg     <= i_plus1;
                found_reg <= '0;
            end
            if (cmd.scan_cmp) begin
                found_reg <= found_reg | match_vec;
                k_reg     <= LEN_W'(k_reg + LEN_W'(1));
            end
            if (fr_set_valid) begin
                frame_valid_reg[fr_widx] <= 1'b1;
            end
            if (cmd.next_ref) begin
                i_reg <= i_plus1;
            end
        end
    end

    // Result register: loaded at the end of a run, held until taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_data_reg <= {{PAD_W{1'b0}}, dropped_reg, misses_reg, hits_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### rtl/optimal_page_replacement_sim.sv
// Top level of the optimal page replacement simulator.
//
// The slave channel takes one page reference per item: the page number in
// s_tdata, and s_tlast marks the final reference of a string. While loading,
// one item is taken every cycle. References past MAX_REFS are dropped and
// set the overflow bit of the result.
// After the final item the block stops taking input and simulates optimal
// replacement over the stored string. Each reference takes a store read and
// then a frame compare. A miss with all frames occupied adds a forward scan,
// a store read and a compare per later reference, ending as soon as the next
// use of every frame is known, or with a replacement step at the string end.
// The one store read port sets this pace. The result is loaded into the
// master register once that is free, and input resumes with that load.
// The master channel gives one item per string: hit count, miss count and
// overflow. The result register holds its item while m_tready is low; a
// following string is loaded meanwhile, and only its own result waits.
// cfg_wr_en writes the frame count at any idle time; it is kept across runs.
// Reset clears all run state, empties the frames and sets four frames.
module optimal_page_replacement_sim #(
    parameter int MAX_REFS   = opr_pkg::DEF_MAX_REFS,
    parameter int MAX_FRAMES = opr_pkg::DEF_MAX_FRAMES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Reference channel.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [opr_pkg::S_DATA_W-1:0]  s_tdata,   // [7:0] page
    input  logic                          s_tlast,   // last_ref
    // Result channel.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [opr_pkg::M_DATA_W-1:0]  m_tdata,   // [8:0] hit_count,
                                                     // [17:9] miss_count,
                                                     // [18] overflow
    // Frame count register.
    input  logic                          cfg_wr_en,
    input  logic [opr_pkg::FC_W-1:0]      cfg_wr_data
);
    import opr_pkg::*;

    opr_cmd_t    cmd;
    opr_status_t st;

    // Controller.
    opr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .st       (st),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    // Datapath.
    opr_dp #(
        .MAX_REFS   (MAX_REFS),
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .in_page     (s_tdata[PAGE_W-1:0]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_ready   (m_tready),
        .st          (st),
        .out_valid   (m_tvalid),
        .out_data    (m_tdata)
    );

endmodule

### rtl/opr_checker.sv
// Port-level checker of the optimal page replacement simulator and its bind.
`include "assert_macros.svh"

module opr_checker #(
    parameter int MAX_REFS = opr_pkg::DEF_MAX_REFS
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tlast,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [opr_pkg::M_DATA_W-1:0]  m_tdata
);
    import opr_pkg::*;

    logic [COUNT_W-1:0] hit_cnt;
    logic [COUNT_W-1:0] miss_cnt;
    logic [COUNT_W-1:0] total_cnt;
    logic               ovf;

    assign hit_cnt   = m_tdata[COUNT_W-1:0];
    assign miss_cnt  = m_tdata[2*COUNT_W-1:COUNT_W];
    assign ovf       = m_tdata[2*COUNT_W];
    assign total_cnt = COUNT_W'(hit_cnt + miss_cnt);

    // No result is offered right after reset.
    `OPR_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // A stalled result keeps its value.
    `OPR_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

    // The final item of a string stops input for the simulation.
    `OPR_ASSERT(a_sim_stall, aclk, aresetn, s_tvalid && s_tready && s_tlast |=> !s_tready, "input taken during simulation")

    // The first reference of a string always misses.
    `OPR_ASSERT(a_first_miss, aclk, aresetn, m_tvalid |-> miss_cnt != '0, "result without a miss")

    // A dropped reference means the store was full: every stored one counted.
    `OPR_ASSERT(a_ovf_total, aclk, aresetn, m_tvalid && ovf |-> total_cnt == COUNT_W'(MAX_REFS), "overflow with short count")

endmodule

bind optimal_page_replacement_sim opr_checker #(.MAX_REFS(MAX_REFS)) u_opr_checker (.*);
